// ----- rtl/daisy_chain_frame_receiver_core_assert.svh -----
// assertion macros for the daisy-chain frame receiver checker
// relies on clk and rst_n being visible where a macro is used
`ifndef DAISY_CHAIN_FRAME_RECEIVER_CORE_ASSERT_SVH
`define DAISY_CHAIN_FRAME_RECEIVER_CORE_ASSERT_SVH

// clocked assertion, switched off while reset is held
`define DCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also runs through reset
`define DCFR_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/dcfr_pkg.sv -----
// shared types and constants for the daisy-chain frame receiver
// no dependencies
`timescale 1ns / 1ps

package dcfr_pkg;

  localparam logic [7:0]  SYNC_BYTE    = 8'hCA;
  localparam logic [15:0] BROADCAST_EP = 16'hFFFF;
  localparam logic [7:0]  PAYLOAD_MAX  = 8'd255;

  // two banks of 256 bytes
  localparam int BANK_AW = 8;
  localparam int ADDR_W  = BANK_AW + 1;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic KIND_SERIAL = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic RES_FRAME = 1'b0;
  localparam logic RES_READ  = 1'b1;

  localparam logic [1:0] ROUTE_BCAST = 2'd0;
  localparam logic [1:0] ROUTE_LOCAL = 2'd1;
  localparam logic [1:0] ROUTE_FWD   = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  command;
    logic [7:0]  payload_length;
    logic [7:0]  command_length;
    logic [1:0]  route;
    logic [15:0] next_endpoint;
  } res_t;

  // result tdata layout, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  payload_byte;
    logic [15:0] next_endpoint;
    logic [1:0]  route;
    logic [7:0]  command_length;
    logic [7:0]  payload_length;
    logic [7:0]  command;
  } out_data_t;

endpackage

// ----- rtl/dcfr_parser.sv -----
// frame parser: field sequencer, checksum, routing, payload store and payload read requests
// depends on dcfr_pkg
`timescale 1ns / 1ps

module dcfr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic             kind,
  input  logic [7:0]       data_byte,
  input  logic [7:0]       read_index,
  output dcfr_pkg::wr_req_t wr,
  output dcfr_pkg::rd_req_t rd,
  output dcfr_pkg::res_t    res
);
  import dcfr_pkg::*;

  localparam logic [3:0] FP_HUNT    = 4'd0;
  localparam logic [3:0] FP_LEN     = 4'd1;
  localparam logic [3:0] FP_CMDLEN  = 4'd2;
  localparam logic [3:0] FP_CMD     = 4'd3;
  localparam logic [3:0] FP_PAYLOAD = 4'd4;
  localparam logic [3:0] FP_EP_HI   = 4'd5;
  localparam logic [3:0] FP_EP_LO   = 4'd6;
  localparam logic [3:0] FP_SUM_HI  = 4'd7;
  localparam logic [3:0] FP_SUM_LO  = 4'd8;

  logic [3:0]  fpos_r, fpos_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cmd_len_r, cmd_len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  widx_r, widx_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  sum_hi_r, sum_hi_nxt;
  logic [15:0] ep_r, ep_nxt;
  logic        bank_r, bank_nxt;

  logic        byte_fire;
  logic [7:0]  widx_inc;
  logic [15:0] sum_add;
  logic [1:0]  route;
  logic [15:0] next_ep;

  assign byte_fire = fire && (kind == KIND_SERIAL);
  assign widx_inc  = widx_r + 8'd1;
  assign sum_add   = sum_r + {8'd0, data_byte};

  always_comb begin
    if (ep_r == BROADCAST_EP) begin
      route   = ROUTE_BCAST;
      next_ep = ep_r;
    end else if (ep_r == 16'd0) begin
      route   = ROUTE_LOCAL;
      next_ep = 16'd0;
    end else begin
      route   = ROUTE_FWD;
      next_ep = ep_r - 16'd1;
    end
  end

  always_comb begin
    fpos_nxt    = fpos_r;
    len_nxt     = len_r;
    cmd_len_nxt = cmd_len_r;
    cmd_nxt     = cmd_r;
    widx_nxt    = widx_r;
    sum_nxt     = sum_r;
    sum_hi_nxt  = sum_hi_r;
    ep_nxt      = ep_r;
    bank_nxt    = bank_r;
    wr          = '0;
    res         = '0;

    // reads always come from the bank completed last
    rd.re   = fire && (kind == KIND_READ);
    rd.addr = {~bank_r, read_index};

    if (rd.re) begin
      res.valid = 1'b1;
      res.kind  = RES_READ;
    end

    if (byte_fire) begin
      case (fpos_r)
        FP_HUNT: begin
          if (data_byte == SYNC_BYTE) begin
            sum_nxt  = {8'd0, SYNC_BYTE};
            fpos_nxt = FP_LEN;
          end
        end
        FP_LEN: begin
          if (data_byte > PAYLOAD_MAX) begin
            fpos_nxt = FP_HUNT;
          end else begin
            len_nxt  = data_byte;
            sum_nxt  = sum_add;
            fpos_nxt = FP_CMDLEN;
          end
        end
        FP_CMDLEN: begin
          if (data_byte <= len_r) begin
            cmd_len_nxt = data_byte;
            widx_nxt    = 8'd0;
            sum_nxt     = sum_add;
            fpos_nxt    = FP_CMD;
          end else begin
            fpos_nxt = FP_HUNT;
          end
        end
        FP_CMD: begin
          cmd_nxt  = data_byte;
          sum_nxt  = sum_add;
          fpos_nxt = FP_PAYLOAD;
        end
        FP_PAYLOAD: begin
          wr.we    = 1'b1;
          wr.addr  = {bank_r, widx_r};
          wr.data  = data_byte;
          widx_nxt = widx_inc;
          sum_nxt  = sum_add;
          // zero length still stores one byte
          if (widx_inc >= len_r) begin
            fpos_nxt = FP_EP_HI;
          end
        end
        FP_EP_HI: begin
          ep_nxt   = {data_byte, 8'd0};
          sum_nxt  = sum_add;
          fpos_nxt = FP_EP_LO;
        end
        FP_EP_LO: begin
          ep_nxt   = {ep_r[15:8], data_byte};
          sum_nxt  = sum_add;
          fpos_nxt = FP_SUM_HI;
        end
        FP_SUM_HI: begin
          sum_hi_nxt = data_byte;
          fpos_nxt   = FP_SUM_LO;
        end
        FP_SUM_LO: begin
          if ({sum_hi_r, data_byte} == sum_r) begin
            bank_nxt           = ~bank_r;
            res.valid          = 1'b1;
            res.kind           = RES_FRAME;
            res.command        = cmd_r;
            res.payload_length = len_r;
            res.command_length = cmd_len_r;
            res.route          = route;
            res.next_endpoint  = next_ep;
          end
          fpos_nxt = FP_HUNT;
        end
        default: begin
          fpos_nxt = FP_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpos_r    <= FP_HUNT;
      len_r     <= 8'd0;
      cmd_len_r <= 8'd0;
      cmd_r     <= 8'd0;
      widx_r    <= 8'd0;
      sum_r     <= 16'd0;
      sum_hi_r  <= 8'd0;
      ep_r      <= 16'd0;
      bank_r    <= 1'b0;
    end else begin
      fpos_r    <= fpos_nxt;
      len_r     <= len_nxt;
      cmd_len_r <= cmd_len_nxt;
      cmd_r     <= cmd_nxt;
      widx_r    <= widx_nxt;
      sum_r     <= sum_nxt;
      sum_hi_r  <= sum_hi_nxt;
      ep_r      <= ep_nxt;
      bank_r    <= bank_nxt;
    end
  end

endmodule

// ----- rtl/dcfr_payload_ram.sv -----
// two-bank payload store, one write and one registered read per cycle
// depends on dcfr_pkg
`timescale 1ns / 1ps

module dcfr_payload_ram (
  input  logic              clk,
  input  dcfr_pkg::wr_req_t wr,
  input  dcfr_pkg::rd_req_t rd,
  output logic [7:0]        rdata
);
  import dcfr_pkg::*;

  logic [7:0] mem_r [MEM_DEPTH];
  logic [7:0] rdata_r;

  // read data holds until the next read request
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rdata_r <= mem_r[rd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/dcfr_out_stage.sv -----
// result pipeline: one stage waiting on ram read data, then the output register
// depends on dcfr_pkg
`timescale 1ns / 1ps

module dcfr_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dcfr_pkg::res_t          res,
  input  logic [7:0]              rdata,
  input  logic                    out_tready,
  output logic                    take,
  output logic                    out_tvalid,
  output dcfr_pkg::out_data_t     out_data,
  output logic                    out_kind
);
  import dcfr_pkg::*;

  logic      s1_v_r, s1_v_nxt;
  res_t      s1_r;
  logic      o_v_r, o_v_nxt;
  out_data_t o_data_r;
  logic      o_kind_r;
  logic      adv;

  assign adv  = s1_v_r && (!o_v_r || out_tready);
  assign take = !s1_v_r || adv;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (res.valid) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
    o_v_nxt = o_v_r;
    if (adv) begin
      o_v_nxt = 1'b1;
    end else if (out_tready) begin
      o_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      s1_r <= res;
    end
    if (adv) begin
      o_kind_r                <= s1_r.kind;
      o_data_r.pad            <= '0;
      o_data_r.command        <= s1_r.command;
      o_data_r.payload_length <= s1_r.payload_length;
      o_data_r.command_length <= s1_r.command_length;
      o_data_r.route          <= s1_r.route;
      o_data_r.next_endpoint  <= s1_r.next_endpoint;
      // ram data is held since no read can be issued while this stage waits
      o_data_r.payload_byte   <= (s1_r.kind == RES_READ) ? rdata : 8'd0;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_data   = o_data_r;
  assign out_kind   = o_kind_r;

endmodule

// ----- rtl/daisy_chain_frame_receiver_core.sv -----
// channel  | signals                        | moves
// in       | in_tvalid/in_tready/in_tdata   | serial byte or payload read request
// out      | out_tvalid/out_tready/out_tdata| frame report or payload read data
//
// one request a cycle while in_tready is high; a result passes the read stage and the output register
// the payload ram read is registered, which sets the result stage timing
// rst_n clears the parser and handshake state; the payload ram is not cleared
// a stalled output holds one result and one more in the read stage before
// in_tready drops
// top level of the daisy-chain frame receiver; depends on dcfr_pkg and the dcfr_* modules
`timescale 1ns / 1ps

module daisy_chain_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte[7:0], read_index[15:8]
  input  logic        in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // command[7:0], payload_length[15:8], command_length[23:16], route[25:24],
  // next_endpoint[41:26], payload_byte[49:42], zero[55:50]
  output logic [55:0] out_tdata,
  output logic        out_tuser   // result_kind[0]
);
  import dcfr_pkg::*;

  logic      fire;
  logic      take;
  wr_req_t   wr;
  rd_req_t   rd;
  res_t      res;
  logic [7:0] rdata;
  out_data_t out_data;

  assign in_tready = take;
  assign fire      = in_tvalid && in_tready;

  dcfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .kind       (in_tuser),
    .data_byte  (in_tdata[7:0]),
    .read_index (in_tdata[15:8]),
    .wr         (wr),
    .rd         (rd),
    .res        (res)
  );

  dcfr_payload_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  dcfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .rdata      (rdata),
    .out_tready (out_tready),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_data   (out_data),
    .out_kind   (out_tuser)
  );

  assign out_tdata = out_data;

endmodule

// ----- rtl/dcfr_checker.sv -----
// port-level checks for the daisy-chain frame receiver, bound to the top level
// depends on dcfr_pkg and daisy_chain_frame_receiver_core_assert.svh
`timescale 1ns / 1ps

`include "daisy_chain_frame_receiver_core_assert.svh"

module dcfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);
  import dcfr_pkg::*;

  out_data_t d;
  logic      frame_v;
  logic      read_v;
  logic      stalled;
  logic      read_zero;
  logic      frame_ok;
  logic      ep_ok;

  assign d       = out_tdata;
  assign frame_v = out_tvalid && (out_tuser == RES_FRAME);
  assign read_v  = out_tvalid && (out_tuser == RES_READ);
  assign stalled = out_tvalid && !out_tready;

  // a read result carries only its byte
  assign read_zero = (d.command == 8'd0) && (d.payload_length == 8'd0) &&
                     (d.command_length == 8'd0) && (d.route == ROUTE_BCAST) &&
                     (d.next_endpoint == 16'd0);
  assign frame_ok  = (d.payload_byte == 8'd0) && (d.command_length <= d.payload_length);
  assign ep_ok     = (d.route == ROUTE_LOCAL) ? (d.next_endpoint == 16'd0) :
                     (d.route == ROUTE_BCAST) ? (d.next_endpoint == BROADCAST_EP) : 1'b1;

  `DCFR_ASSERT_ANY(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")

  `DCFR_ASSERT(a_stall_hold, stalled |=> out_tvalid && $stable(out_tdata), "stalled result moved")

  `DCFR_ASSERT(a_read_fields, read_v |-> read_zero, "read result carries frame fields")

  `DCFR_ASSERT(a_frame_fields, frame_v |-> frame_ok, "frame result fields inconsistent")

  `DCFR_ASSERT(a_route_ep, frame_v |-> ep_ok, "route and endpoint disagree")

endmodule

bind daisy_chain_frame_receiver_core dcfr_checker u_dcfr_checker (.*);
